FILE: hdl/telnet_strip_line_splitter_assert.svh
// Assertion macros for the telnet strip line splitter.
// Used by tsls_core and telnet_strip_line_splitter; no other dependencies.
`ifndef TELNET_STRIP_LINE_SPLITTER_ASSERT_SVH
`define TELNET_STRIP_LINE_SPLITTER_ASSERT_SVH

// Implication checked every clock, off during reset.
`define TSLS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define TSLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tsls_pkg.sv
// Package for the telnet strip line splitter: byte codes, CSR indexes and
// transaction structs. No dependencies.
`default_nettype none

package tsls_pkg;

   localparam logic [7:0] CH_IAC  = 8'd255;
   localparam logic [7:0] CH_SB   = 8'd250;
   localparam logic [7:0] CH_SE   = 8'd240;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [1:0] IAC_DROP_COUNT = 2'd3;

   localparam logic ACTION_DATA  = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   localparam logic CSR_TELNET_FILTER_ENABLE = 1'b0;
   localparam logic CSR_FLUSH_PARTIAL_LINES  = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       chunk_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       line_end;
   } rsp_item_type;

   typedef struct packed {
      logic telnet_filter_enable;
      logic flush_partial_lines;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hdl/tsls_in_reg.sv
// Input register of the telnet strip line splitter.
// Depends on tsls_pkg.
`default_nettype none

module tsls_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tsls_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output tsls_pkg::req_item_type     item
);

   logic                   valid_ff, valid_in;
   tsls_pkg::req_item_type item_ff, item_in;
   logic                   req_fire;

   assign req_ready = !valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: hdl/tsls_core.sv
// Telnet filter and line splitter state with the per-byte result logic.
// Depends on tsls_pkg and telnet_strip_line_splitter_assert.svh.
`default_nettype none
`include "telnet_strip_line_splitter_assert.svh"

module tsls_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tsls_pkg::cfg_type      cfg,
   input  wire tsls_pkg::req_item_type item,
   input  wire logic                   fire,
   output tsls_pkg::rsp_item_type      result,
   output logic                        has_result
);

   logic       prev_was_cr_ff, prev_was_cr_in;
   logic       line_has_chars_ff, line_has_chars_in;
   logic [1:0] cmd_left_ff, cmd_left_in;
   logic       in_subneg_ff, in_subneg_in;
   logic [1:0] cmd_after;
   logic       subneg_after;
   logic       keep, kept, is_cr, is_lf;
   logic       lend, bvalid, lhc_mid;

   assign is_cr = (item.data_byte == tsls_pkg::CH_CR);
   assign is_lf = (item.data_byte == tsls_pkg::CH_LF);

   // telnet command tracking
   always_comb begin
      cmd_after    = cmd_left_ff;
      subneg_after = in_subneg_ff;
      keep         = !item.data_byte[7];
      if (item.data_byte == tsls_pkg::CH_IAC) begin
         cmd_after = tsls_pkg::IAC_DROP_COUNT;
      end else if (item.data_byte == tsls_pkg::CH_SB) begin
         subneg_after = 1'b1;
      end else if (item.data_byte == tsls_pkg::CH_SE) begin
         subneg_after = 1'b0;
         cmd_after    = 2'd0;
      end
      if (cmd_after != 2'd0) begin
         cmd_after = cmd_after - 2'd1;
         keep      = 1'b0;
      end
      if (subneg_after) begin
         keep = 1'b0;
      end
   end

   assign kept = !cfg.telnet_filter_enable || keep;

   always_comb begin
      prev_was_cr_in    = prev_was_cr_ff;
      line_has_chars_in = line_has_chars_ff;
      cmd_left_in       = cmd_left_ff;
      in_subneg_in      = in_subneg_ff;
      lend              = 1'b0;
      bvalid            = 1'b0;
      lhc_mid           = line_has_chars_ff;
      has_result        = 1'b0;
      if (item.action == tsls_pkg::ACTION_FLUSH) begin
         lend              = 1'b1;
         has_result        = line_has_chars_ff;
         line_has_chars_in = 1'b0;
      end else begin
         if (cfg.telnet_filter_enable) begin
            cmd_left_in  = cmd_after;
            in_subneg_in = subneg_after;
         end
         if (kept) begin
            if (is_cr || is_lf) begin
               if (is_cr || !prev_was_cr_ff) begin
                  lend    = 1'b1;
                  lhc_mid = 1'b0;
               end
            end else begin
               bvalid  = 1'b1;
               lhc_mid = 1'b1;
            end
            prev_was_cr_in = is_cr;
         end
         line_has_chars_in = lhc_mid;
         if (item.chunk_end && cfg.flush_partial_lines && lhc_mid) begin
            lend              = 1'b1;
            line_has_chars_in = 1'b0;
         end
         has_result = bvalid || lend;
      end
   end

   assign result.out_byte   = bvalid ? item.data_byte : 8'd0;
   assign result.byte_valid = bvalid;
   assign result.line_end   = lend;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_was_cr_ff    <= 1'b0;
         line_has_chars_ff <= 1'b0;
         cmd_left_ff       <= 2'd0;
         in_subneg_ff      <= 1'b0;
      end else if (fire) begin
         prev_was_cr_ff    <= prev_was_cr_in;
         line_has_chars_ff <= line_has_chars_in;
         cmd_left_ff       <= cmd_left_in;
         in_subneg_ff      <= in_subneg_in;
      end
   end

   `TSLS_ASSERT_NEXT(a_filter_off_telnet_idle, clock, reset, !cfg.telnet_filter_enable, $stable(cmd_left_ff) && $stable(in_subneg_ff), "telnet state moved with filter off")
   `TSLS_ASSERT_IMPL(a_subneg_drops, clock, reset, cfg.telnet_filter_enable && in_subneg_ff && item.action == tsls_pkg::ACTION_DATA && item.data_byte != tsls_pkg::CH_SE, !result.byte_valid, "byte kept inside subnegotiation")

endmodule

`default_nettype wire

FILE: hdl/telnet_strip_line_splitter.sv
// Top level of the telnet strip line splitter: CSRs, result register.
// Depends on tsls_pkg, tsls_in_reg, tsls_core, telnet_strip_line_splitter_assert.svh.
`default_nettype none
`include "telnet_strip_line_splitter_assert.svh"

// Takes one received byte (or flush event) per clock unless a held result stalls
// it, and returns at most one result per transaction: a text character, a line
// end, or both. Throughput is one transaction per clock while rsp_ready keeps up.
// A result passes through the input register, then the result register, and
// stays until taken. Transactions that produce no result are consumed without a
// response. CSRs must be written only while the block is idle.
module telnet_strip_line_splitter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_action,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_chunk_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_line_end,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic       csr_write_data
);

   tsls_pkg::cfg_type      cfg_ff, cfg_in;
   tsls_pkg::req_item_type req_item, item;
   tsls_pkg::rsp_item_type result, rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   item_valid, has_result, advance;

   assign req_item.action    = req_action;
   assign req_item.data_byte = req_data_byte;
   assign req_item.chunk_end = req_chunk_end;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tsls_pkg::CSR_TELNET_FILTER_ENABLE: cfg_in.telnet_filter_enable = csr_write_data;
            tsls_pkg::CSR_FLUSH_PARTIAL_LINES:  cfg_in.flush_partial_lines  = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   tsls_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tsls_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .fire       (advance),
      .result     (result),
      .has_result (has_result)
   );

   assign advance = item_valid && (!has_result || !rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_line_end   = rsp_ff.line_end;

   `TSLS_ASSERT_IMPL(a_rsp_not_empty, clock, reset, rsp_valid,
      rsp_byte_valid || rsp_line_end, "empty result delivered")
   `TSLS_ASSERT_IMPL(a_rsp_byte_zero, clock, reset, rsp_valid && !rsp_byte_valid,
      rsp_out_byte == 8'd0, "out_byte set without byte_valid")
   `TSLS_ASSERT_IMPL(a_no_overwrite, clock, reset,
      rsp_valid_ff && !rsp_ready && item_valid && has_result,
      !advance, "result overwritten while stalled")

endmodule

`default_nettype wire

FILE: test/telnet_strip_line_splitter_tb.sv
// Testbench for telnet_strip_line_splitter: directed and random byte streams, checked
// against a built-in model of the telnet filter and the CR/LF line framer.
// Depends on tsls_pkg and the telnet_strip_line_splitter RTL.
`timescale 1ns / 100ps

module telnet_strip_line_splitter_tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = tsls_pkg::ACTION_DATA;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_line_end;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = tsls_pkg::CSR_TELNET_FILTER_ENABLE;
   logic       csr_write_data = 1'b0;

   // model state and configuration
   logic       filter_on = 1'b0;
   logic       flush_on = 1'b0;
   logic       prev_cr = 1'b0;
   logic       line_open = 1'b0;
   logic [1:0] cmd_left = 2'd0;
   logic       in_sb = 1'b0;

   tsls_pkg::rsp_item_type line_events_q[$];
   tsls_pkg::rsp_item_type expected_ev;
   int mismatches = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;

   localparam int HOLD_CYCLES = 300;

   telnet_strip_line_splitter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .req_chunk_end    (req_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_line_end     (rsp_line_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void predict_line_event(input tsls_pkg::req_item_type t);
      tsls_pkg::rsp_item_type r;
      logic keep;
      r = '0;
      if (t.action == tsls_pkg::ACTION_FLUSH) begin
         if (line_open) begin
            line_open = 1'b0;
            r.line_end = 1'b1;
            line_events_q.push_back(r);
         end
         return;
      end
      keep = 1'b1;
      if (filter_on) begin
         keep = ~t.data_byte[7];
         if (t.data_byte == tsls_pkg::CH_IAC) begin
            cmd_left = tsls_pkg::IAC_DROP_COUNT;
         end else if (t.data_byte == tsls_pkg::CH_SB) begin
            in_sb = 1'b1;
         end else if (t.data_byte == tsls_pkg::CH_SE) begin
            in_sb = 1'b0;
            cmd_left = 2'd0;
         end
         if (cmd_left != 2'd0) begin
            cmd_left = cmd_left - 2'd1;
            keep = 1'b0;
         end
         if (in_sb) keep = 1'b0;
      end
      if (keep) begin
         if (t.data_byte == tsls_pkg::CH_CR || t.data_byte == tsls_pkg::CH_LF) begin
            if (t.data_byte == tsls_pkg::CH_CR || !prev_cr) begin
               r.line_end = 1'b1;
               line_open = 1'b0;
            end
         end else begin
            r.out_byte = t.data_byte;
            r.byte_valid = 1'b1;
            line_open = 1'b1;
         end
         prev_cr = (t.data_byte == tsls_pkg::CH_CR);
      end
      if (t.chunk_end && flush_on && line_open) begin
         r.line_end = 1'b1;
         line_open = 1'b0;
      end
      if (r.byte_valid || r.line_end) line_events_q.push_back(r);
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_events_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction byte=%02h valid=%0b end=%0b",
               $time, rsp_out_byte, rsp_byte_valid, rsp_line_end);
         end else begin
            expected_ev = line_events_q.pop_front();
            if (rsp_out_byte !== expected_ev.out_byte ||
                rsp_byte_valid !== expected_ev.byte_valid ||
                rsp_line_end !== expected_ev.line_end) begin
               mismatches++;
               $display({"%0t: mismatch expected byte=%02h valid=%0b end=%0b, ",
                  "got byte=%02h valid=%0b end=%0b"},
                  $time, expected_ev.out_byte, expected_ev.byte_valid,
                  expected_ev.line_end, rsp_out_byte, rsp_byte_valid, rsp_line_end);
            end
         end
      end
   end

   // receiver: random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_req(input logic action, input logic [7:0] b, input logic ce);
      tsls_pkg::req_item_type t;
      t.action = action;
      t.data_byte = b;
      t.chunk_end = ce;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_data_byte <= b;
      req_chunk_end <= ce;
      do begin
         @(posedge clock);
      end while (!req_ready);
      items_sent++;
      predict_line_event(t);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic ce);
      send_req(tsls_pkg::ACTION_DATA, b, ce);
   endtask

   task automatic send_text(input logic [7:0] b);
      send_req(tsls_pkg::ACTION_DATA, b, $urandom_range(7) == 0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (line_events_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == tsls_pkg::CSR_TELNET_FILTER_ENABLE) filter_on = val;
      else flush_on = val;
   endtask

   task automatic set_config(input logic filt, input logic flush);
      write_csr(tsls_pkg::CSR_TELNET_FILTER_ENABLE, filt);
      write_csr(tsls_pkg::CSR_FLUSH_PARTIAL_LINES, flush);
   endtask

   task automatic test_plain_lines();
      set_config(1'b0, 1'b0);
      send_byte(8'h48, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(tsls_pkg::CH_CR, 1'b0);
      send_byte(tsls_pkg::CH_LF, 1'b0);
      send_byte(tsls_pkg::CH_LF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_req(tsls_pkg::ACTION_FLUSH, 8'hFF, 1'b1);
      send_req(tsls_pkg::ACTION_FLUSH, 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_telnet_filter();
      set_config(1'b1, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(tsls_pkg::CH_IAC, 1'b0);
      send_byte(8'd251, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(tsls_pkg::CH_CR, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(tsls_pkg::CH_LF, 1'b0);
      send_byte(tsls_pkg::CH_SB, 1'b0);
      send_byte(8'h7A, 1'b0);
      send_byte(tsls_pkg::CH_IAC, 1'b0);
      send_byte(tsls_pkg::CH_SE, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(tsls_pkg::CH_CR, 1'b0);
      drain_results();
   endtask

   task automatic test_chunk_flush();
      set_config(1'b1, 1'b1);
      send_byte(8'h71, 1'b1);
      send_byte(8'h72, 1'b0);
      send_byte(tsls_pkg::CH_IAC, 1'b1);
      send_byte(tsls_pkg::CH_SE, 1'b0);
      send_byte(tsls_pkg::CH_CR, 1'b1);
      send_byte(tsls_pkg::CH_LF, 1'b1);
      drain_results();
   endtask

   task automatic send_random_unit();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_text(8'($urandom_range(126, 32)));
      end else if (pick < 60) begin
         case ($urandom_range(2))
            0: send_text(tsls_pkg::CH_CR);
            1: send_text(tsls_pkg::CH_LF);
            default: begin
               send_text(tsls_pkg::CH_CR);
               send_text(tsls_pkg::CH_LF);
            end
         endcase
      end else if (pick < 68) begin
         send_text(tsls_pkg::CH_IAC);
         send_text(8'($urandom_range(255, 240)));
         send_text(8'($urandom_range(255)));
      end else if (pick < 75) begin
         send_text(tsls_pkg::CH_SB);
         len = $urandom_range(4);
         repeat (len) send_text(8'($urandom_range(255)));
         if ($urandom_range(1)) send_text(tsls_pkg::CH_IAC);
         send_text(tsls_pkg::CH_SE);
      end else if (pick < 83) begin
         send_req(tsls_pkg::ACTION_FLUSH, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
         send_text(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_items(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) send_random_unit();
   endtask

   task automatic test_random_traffic(input int n);
      for (int s = 0; s < 4; s++) begin
         drain_results();
         set_config(s[0], s[1]);
         run_random_items(n / 2);
         drain_results();
         run_random_items(n - n / 2);
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      drain_results();
      set_config(1'b1, 1'b1);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_seq++;
      run_random_items(100);
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_plain_lines();
      test_telnet_filter();
      test_chunk_flush();
      send_idle_pct = 11;
      rsp_idle_pct = 86;
      test_random_traffic(115);
      send_idle_pct = 86;
      rsp_idle_pct = 11;
      test_random_traffic(115);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(115);
      test_backpressure();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/tsls_pkg.sv
hdl/tsls_in_reg.sv
hdl/tsls_core.sv
hdl/telnet_strip_line_splitter.sv
test/telnet_strip_line_splitter_tb.sv
